// ===== hw/rtl/mns_pkg.sv =====
// Package for the melody note sequencer: beat payload types, command codes,
// the built-in melody note table and the melody start table. No dependencies.
`default_nettype none

package mns_pkg;

  localparam int MELODY_ROM_DEPTH = 64;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_FREQ  = 2'd1;
  localparam logic [1:0] MODE_SOUND = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  localparam logic [3:0] SOUND_COUNT = 4'd8;
  localparam logic [15:0] FREQ_MAX   = 16'hFFFF;
  localparam logic [15:0] DUR_MIN    = 16'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] freq;
    logic signed [15:0] duration;
    logic [3:0]         sound_number;
    logic               loop;
  } cmd_t;

  typedef struct packed {
    logic        tone_load;
    logic [15:0] tone_freq;
    logic        fill_buffer;
    logic        finished;
    logic        rejected;
    logic        playing;
  } res_t;

  typedef struct packed {
    logic [15:0] f;
    logic [15:0] d;
  } note_t;

  // Built-in note table; entries past the last melody and past the ROM depth
  // read as a zero note, which ends a melody.
  function automatic note_t rom_note(logic [7:0] idx);
    note_t n;
    n = '0;
    if (int'(idx) < MELODY_ROM_DEPTH) begin
      case (idx)
        8'd0:  n = '{16'd3400, 16'd12};
        8'd1:  n = '{16'd4400, 16'd6};
        8'd2:  n = '{16'd5100, 16'd6};
        8'd3:  n = '{16'd6400, 16'd6};
        8'd4:  n = '{16'd7800, 16'd6};
        8'd6:  n = '{16'd7800, 16'd12};
        8'd7:  n = '{16'd6400, 16'd6};
        8'd8:  n = '{16'd5100, 16'd6};
        8'd9:  n = '{16'd4400, 16'd6};
        8'd10: n = '{16'd3400, 16'd6};
        8'd12: n = '{16'd1100, 16'd6};
        8'd13: n = '{16'd2200, 16'd6};
        8'd15: n = '{16'd3300, 16'd6};
        8'd16: n = '{16'd4400, 16'd12};
        8'd17: n = '{16'd6600, 16'd6};
        8'd19: n = '{16'(20280 / 2), 16'd1};
        8'd20: n = '{16'(17750 / 2), 16'd1};
        8'd21: n = '{16'(14650 / 2), 16'd1};
        8'd22: n = '{16'(12790 / 2), 16'd1};
        8'd23: n = '{16'(25690 / 2), 16'd1};
        8'd24: n = '{16'(23140 / 2), 16'd1};
        8'd25: n = '{16'(20620 / 2), 16'd1};
        8'd26: n = '{16'(19920 / 2), 16'd1};
        8'd27: n = '{16'(17790 / 2), 16'd1};
        8'd28: n = '{16'(12790 / 2), 16'd1};
        8'd29: n = '{16'(26110 / 2), 16'd1};
        8'd30: n = '{16'(16780 / 2), 16'd1};
        8'd31: n = '{16'(24300 / 2), 16'd1};
        8'd32: n = '{16'(23640 / 2), 16'd1};
        8'd33: n = '{16'(22940 / 2), 16'd1};
        8'd34: n = '{16'(29690 / 2), 16'd1};
        8'd36: n = '{16'd6600, 16'd4};
        8'd37: n = '{16'd2750, 16'd4};
        8'd39: n = '{16'd4400, 16'd6};
        8'd40: n = '{16'd5500, 16'd6};
        8'd42: n = '{16'd4400, 16'd6};
        8'd43: n = '{16'd5500, 16'd6};
        8'd44: n = '{16'd6600, 16'd6};
        default: n = '0;
      endcase
    end
    return n;
  endfunction

  // First note of each built-in melody, indexed by sound number minus one.
  function automatic logic [7:0] melody_base(logic [2:0] sel);
    logic [7:0] b;
    case (sel)
      3'd0:    b = 8'd0;
      3'd1:    b = 8'd6;
      3'd2:    b = 8'd12;
      3'd3:    b = 8'd15;
      3'd4:    b = 8'd19;
      3'd5:    b = 8'd36;
      3'd6:    b = 8'd39;
      default: b = 8'd42;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mns_in_stage.sv =====
// Input register of the melody note sequencer: holds one command beat
// until the sequencer core takes it. Depends on mns_pkg.
`default_nettype none

module mns_in_stage (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire mns_pkg::cmd_t in_item,
  output logic             cmd_valid,
  output mns_pkg::cmd_t    cmd,
  input  wire logic        take
);
  import mns_pkg::*;

  assign in_ready = !cmd_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      cmd <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mns_seq_core.sv =====
// Sequencer core: playback state, command decode, note table lookup and the
// result register. Depends on mns_pkg.
`default_nettype none

module mns_seq_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        cmd_valid,
  input  wire mns_pkg::cmd_t cmd,
  output logic             take,
  output logic             out_valid,
  input  wire logic        out_ready,
  output mns_pkg::res_t    out_item
);
  import mns_pkg::*;

  logic               events_enable;
  logic signed [15:0] note_countdown, note_countdown_next;
  logic [7:0]         note_pointer, note_pointer_next;
  logic [7:0]         melody_start, melody_start_next;
  logic               melody_mode, melody_mode_next;
  logic               loop_flag, loop_flag_next;
  logic               active, active_next;

  res_t        res;
  logic        ended;
  logic [7:0]  ptr_inc;
  logic [7:0]  sound_base;
  note_t       note_adv, note_restart, note_first;
  logic [16:0] mag;
  logic [20:0] f10;
  logic [15:0] dur_fix;

  assign take = cmd_valid && (!out_valid || out_ready);

  assign ptr_inc      = note_pointer + 8'd1;
  assign sound_base   = melody_base(3'(cmd.sound_number - 4'd1));
  assign note_adv     = rom_note(ptr_inc);
  assign note_restart = rom_note(melody_start);
  assign note_first   = rom_note(sound_base);

  // Frequency magnitude times ten, by shift and add.
  assign mag = cmd.freq[15] ? (17'h10000 - {1'b0, cmd.freq}) : {1'b0, cmd.freq};
  assign f10 = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};

  always_comb begin
    dur_fix = cmd.duration;
    if (cmd.duration != 16'd0 && cmd.duration < DUR_MIN) begin
      dur_fix = DUR_MIN;
    end
  end

  always_comb begin
    note_countdown_next = note_countdown;
    note_pointer_next   = note_pointer;
    melody_start_next   = melody_start;
    melody_mode_next    = melody_mode;
    loop_flag_next      = loop_flag;
    active_next         = active;
    res                 = '0;
    ended               = 1'b0;

    unique case (cmd.mode)
      MODE_TICK: begin
        if (active) begin
          if (!note_countdown[15]) begin
            note_countdown_next = note_countdown - 16'sd1;
            if (note_countdown == 16'sd0) begin
              if (melody_mode) begin
                note_pointer_next = ptr_inc;
                if (note_adv.d != 16'd0) begin
                  note_countdown_next = note_adv.d;
                  res.tone_load       = 1'b1;
                  res.tone_freq       = note_adv.f;
                end else if (!loop_flag) begin
                  note_countdown_next = '0;
                  melody_mode_next    = 1'b0;
                  ended               = 1'b1;
                end else begin
                  // restart the looped melody at its first note
                  note_pointer_next   = melody_start;
                  note_countdown_next = note_restart.d;
                  res.tone_load       = 1'b1;
                  res.tone_freq       = note_restart.f;
                end
              end else begin
                note_countdown_next = '0;
                ended               = 1'b1;
              end
            end
          end
          if (ended) begin
            active_next  = 1'b0;
            res.finished = events_enable;
          end else begin
            res.fill_buffer = 1'b1;
          end
        end
      end
      MODE_FREQ: begin
        if (cmd.duration[15]) begin
          active_next = 1'b0;
        end else begin
          melody_mode_next = 1'b0;
          res.tone_load    = 1'b1;
          res.tone_freq    = (f10[20:16] != 5'd0) ? FREQ_MAX : f10[15:0];
          // zero duration holds the note until stopped
          note_countdown_next = (dur_fix == 16'd0) ? -16'sd1 : dur_fix;
          active_next         = 1'b1;
        end
      end
      MODE_SOUND: begin
        if (cmd.sound_number == 4'd0) begin
          active_next = 1'b0;
        end else if (cmd.sound_number <= SOUND_COUNT) begin
          melody_start_next   = sound_base;
          note_pointer_next   = sound_base;
          loop_flag_next      = cmd.loop;
          melody_mode_next    = 1'b1;
          res.tone_load       = 1'b1;
          res.tone_freq       = note_first.f;
          note_countdown_next = note_first.d;
          active_next         = 1'b1;
        end else begin
          res.rejected = 1'b1;
        end
      end
      MODE_STOP: begin
        active_next = 1'b0;
      end
      default: begin
        active_next = active;
      end
    endcase
    res.playing = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      events_enable  <= 1'b0;
      note_countdown <= '0;
      note_pointer   <= '0;
      melody_start   <= '0;
      melody_mode    <= 1'b0;
      loop_flag      <= 1'b0;
      active         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        events_enable <= cfg_data;
      end
      if (take) begin
        note_countdown <= note_countdown_next;
        note_pointer   <= note_pointer_next;
        melody_start   <= melody_start_next;
        melody_mode    <= melody_mode_next;
        loop_flag      <= loop_flag_next;
        active         <= active_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/melody_note_sequencer.sv =====
// Top level of the melody note sequencer: input register feeding the
// sequencer core. Depends on mns_pkg, mns_in_stage and mns_seq_core.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    in_item  (mns_pkg::cmd_t)
//   out      source     out_valid/out_ready  out_item (mns_pkg::res_t)
//   cfg      sink       cfg_write            cfg_data (events_enable)
//
// One beat per cycle sustained while out_ready stays high; each command
// passes from input to result through the input register, then through
// decode, note table lookup and state update into the result register.
// Synchronous reset clears playback state, events_enable and both valids.
// A stalled output holds its beat while one more command waits in the
// input register.
`default_nettype none

module melody_note_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire mns_pkg::cmd_t in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output mns_pkg::res_t    out_item,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data
);
  import mns_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic take;

  mns_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take)
  );

  mns_seq_core u_seq_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
